>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while out of reset
`define ACP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included
`define ACP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// Types, character codes and arithmetic helpers of the expression evaluator.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int CHAR_W       = 8;
    localparam int VALUE_W      = 32;
    localparam int ERR_W        = 2;
    localparam int NEST_DEPTH_D = 64;

    // Characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Saturation point of a number being read (2^31)
    localparam logic [VALUE_W-1:0] NUM_LIMIT = 32'h8000_0000;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNMATCHED = 2'd1,
        ERR_STACK     = 2'd2,
        ERR_ARITH     = 2'd3
    } t_err;

    // One saved nesting level: sum and sign in force before the '('
    typedef struct packed {
        logic               sign;
        logic [VALUE_W-1:0] sum;
    } t_stk_entry;

    // Add a signed magnitude to a sum, two guard bits kept for overflow
    function automatic logic [VALUE_W+1:0] acp_fold(
        input logic [VALUE_W-1:0] sum,
        input logic               neg,
        input logic [VALUE_W-1:0] mag
    );
        logic [VALUE_W+1:0] m;
        m = {2'b00, mag};
        return {{2{sum[VALUE_W-1]}}, sum} + (neg ? -m : m);
    endfunction

    // True when a guarded sum leaves the signed 32-bit range
    function automatic logic acp_ovf(input logic [VALUE_W+1:0] s);
        return !((s[VALUE_W+1:VALUE_W-1] == 3'b000) ||
                 (s[VALUE_W+1:VALUE_W-1] == 3'b111));
    endfunction

endpackage

>>> design/acp_if.sv
// ----------------------------------------------------------------------------
// acp_if
// Valid/ready channels of the evaluator: character items in, results out.
// ----------------------------------------------------------------------------
interface acp_in_if;
    logic                         valid;
    logic                         ready;
    logic [acp_pkg::CHAR_W-1:0]   char_code;
    logic                         is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface acp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [acp_pkg::VALUE_W-1:0]  value;
    logic [acp_pkg::ERR_W-1:0]           error_code;

    modport source (output valid, output value, output error_code, input ready);
    modport sink   (input valid, input value, input error_code, output ready);
endinterface

>>> design/acp_stack.sv
// ----------------------------------------------------------------------------
// acp_stack
// Nesting stack memory: one write port, one registered read port, with a
// write-to-read bypass when both ports hit the same entry in one cycle.
// ----------------------------------------------------------------------------
module acp_stack #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  acp_pkg::t_stk_entry i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output acp_pkg::t_stk_entry o_rdata
);
    import acp_pkg::*;

    t_stk_entry mem [DEPTH];
    t_stk_entry r_rdata;

    // Write the saved level
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read with bypass of a write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/add_sub_paren_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// add_sub_paren_expression_evaluator_core
// Streaming evaluator of '+', '-' and parenthesised decimal expressions.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one ASCII character per item; is_last marks the final
//   character of an expression. o_out carries one item per expression:
//   the 32-bit two's complement value and a sticky error code (0 ok,
//   1 unmatched close, 2 stack overflow, 3 arithmetic overflow; value is 0
//   whenever the code is not 0).
//   Throughput is one character per cycle unless a stalled receiver leaves
//   both result stages full. The innermost open level sits in a register,
//   the levels below it in a stack memory with one write and one read
//   port, whose next entry is prefetched every cycle, so a ')' right after
//   a '(' or another ')' never waits. A result goes from its last character
//   to the capture stage, then with the final fold to the output register.
//   After the last character all state returns to its reset value, so the
//   next expression may follow in the very next cycle.
//   Reset (i_rst_n low, synchronous) empties the stack, clears the sum and
//   error and drops any pending result; no clearing pass is needed.
//   When the receiver stalls, one result waits in the output register and a
//   second in the capture stage; input stays ready until both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module add_sub_paren_expression_evaluator_core #(
    parameter int NEST_DEPTH = acp_pkg::NEST_DEPTH_D
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acp_in_if.sink    i_in,
    acp_out_if.source o_out
);
    import acp_pkg::*;

    localparam int LW        = $clog2(NEST_DEPTH + 1);
    localparam int MEM_AW    = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // Evaluation state
    logic [VALUE_W-1:0] r_sum,     n_sum;
    logic               r_sign,    n_sign;
    logic [VALUE_W-1:0] r_partial, n_partial;
    logic [LW-1:0]      r_level,   n_level;
    t_err               r_err,     n_err;
    t_stk_entry         r_top,     n_top;

    // Capture stage and output register
    logic               r_fin_valid;
    logic [VALUE_W-1:0] r_fin_sum;
    logic               r_fin_sign;
    logic [VALUE_W-1:0] r_fin_partial;
    t_err               r_fin_err;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    t_err               r_out_err;

    // Post-step values before the end-of-expression clear
    logic [VALUE_W-1:0] s_sum, s_partial;
    logic               s_sign;
    t_err               s_err, e_step;

    logic               in_acc, out_free, fin_move;
    logic               is_digit;
    logic [3:0]         digit;
    logic [VALUE_W+3:0] w_mul;
    logic               mul_ovf;
    logic [VALUE_W+1:0] w_fold, w_comb, w_inner, w_fin;
    logic               fold_ovf, comb_ovf, fin_ovf;
    t_err               fin_err;

    logic               stk_we;
    logic [LW-1:0]      w_lvl_dec, w_lvl_m2;
    t_stk_entry         w_rd;

    // Handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign fin_move   = r_fin_valid && out_free;
    assign i_in.ready = !r_fin_valid || out_free;
    assign in_acc     = i_in.valid && i_in.ready;

    // Character decode and next digit value (x10 as shift-add)
    assign is_digit = (i_in.char_code >= CH_ZERO) && (i_in.char_code <= CH_NINE);
    assign digit    = 4'(i_in.char_code - CH_ZERO);
    assign w_mul    = ({4'b0000, r_partial} << 3) + ({4'b0000, r_partial} << 1)
                    + {{VALUE_W{1'b0}}, digit};
    assign mul_ovf  = w_mul > {4'b0000, NUM_LIMIT};

    // Fold the pending number, then combine with the saved level on ')'
    assign w_fold   = acp_fold(r_sum, r_sign, r_partial);
    assign fold_ovf = acp_ovf(w_fold);
    assign w_inner  = {{2{w_fold[VALUE_W-1]}}, w_fold[VALUE_W-1:0]};
    assign w_comb   = {{2{r_top.sum[VALUE_W-1]}}, r_top.sum}
                    + (r_top.sign ? -w_inner : w_inner);
    assign comb_ovf = acp_ovf(w_comb);

    // Step the evaluation state
    always_comb begin
        s_sum     = r_sum;
        s_sign    = r_sign;
        s_partial = r_partial;
        n_level   = r_level;
        n_top     = r_top;
        stk_we    = 1'b0;
        e_step    = ERR_NONE;
        if (in_acc) begin
            if (is_digit) begin
                s_partial = mul_ovf ? NUM_LIMIT : w_mul[VALUE_W-1:0];
                if (mul_ovf) begin
                    e_step = ERR_ARITH;
                end
            end else begin
                s_sum     = w_fold[VALUE_W-1:0];
                s_partial = '0;
                if (fold_ovf) begin
                    e_step = ERR_ARITH;
                end
                unique case (i_in.char_code)
                    CH_PLUS: begin
                        s_sign = 1'b0;
                    end
                    CH_MINUS: begin
                        s_sign = 1'b1;
                    end
                    CH_OPEN: begin
                        if (r_level < LW'(NEST_DEPTH)) begin
                            stk_we  = (r_level != '0);
                            n_top   = '{sign: r_sign, sum: w_fold[VALUE_W-1:0]};
                            n_level = r_level + LW'(1);
                            s_sum   = '0;
                            s_sign  = 1'b0;
                        end else if (e_step == ERR_NONE) begin
                            e_step = ERR_STACK;
                        end
                    end
                    CH_CLOSE: begin
                        if (r_level != '0) begin
                            n_level = w_lvl_dec;
                            n_top   = w_rd;
                            s_sum   = w_comb[VALUE_W-1:0];
                            s_sign  = r_top.sign;
                            if (comb_ovf && (e_step == ERR_NONE)) begin
                                e_step = ERR_ARITH;
                            end
                        end else if (e_step == ERR_NONE) begin
                            e_step = ERR_UNMATCHED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        s_err = (r_err == ERR_NONE) ? e_step : r_err;

        // Clear everything after the last character
        n_sum     = s_sum;
        n_sign    = s_sign;
        n_partial = s_partial;
        n_err     = s_err;
        if (in_acc && i_in.is_last) begin
            n_sum     = '0;
            n_sign    = 1'b0;
            n_partial = '0;
            n_err     = ERR_NONE;
            n_level   = '0;
        end
    end

    // Stack addressing: write the old top below, prefetch the entry under
    // the next top
    assign w_lvl_dec = r_level - LW'(1);
    assign w_lvl_m2  = n_level - LW'(2);

    acp_stack #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (w_lvl_dec[MEM_AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (w_lvl_m2[MEM_AW-1:0]),
        .o_rdata (w_rd)
    );

    // Hold the evaluation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_sign    <= 1'b0;
            r_partial <= '0;
            r_level   <= '0;
            r_err     <= ERR_NONE;
        end else begin
            r_sum     <= n_sum;
            r_sign    <= n_sign;
            r_partial <= n_partial;
            r_level   <= n_level;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    // Capture the finished expression
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (in_acc && i_in.is_last) begin
            r_fin_valid <= 1'b1;
        end else if (fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.is_last) begin
            r_fin_sum     <= s_sum;
            r_fin_sign    <= s_sign;
            r_fin_partial <= s_partial;
            r_fin_err     <= s_err;
        end
    end

    // Final fold of a trailing number
    assign w_fin   = acp_fold(r_fin_sum, r_fin_sign, r_fin_partial);
    assign fin_ovf = acp_ovf(w_fin);
    assign fin_err = (r_fin_err != ERR_NONE) ? r_fin_err :
                     (fin_ovf ? ERR_ARITH : ERR_NONE);

    // Advance the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out_value <= (fin_err != ERR_NONE) ? '0 : w_fin[VALUE_W-1:0];
            r_out_err   <= fin_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.value      = r_out_value;
    assign o_out.error_code = r_out_err;

    // A last character always fills the capture stage
    `ACP_ASSERT(a_last_captured, (in_acc && i_in.is_last) |=> r_fin_valid,
        "last item not captured")
    // An error result carries a zero value
    `ACP_ASSERT(a_err_zero, (r_out_valid && (r_out_err != ERR_NONE)) |-> (r_out_value == '0),
        "error result with non-zero value")
    // A push that keeps the expression open is read back through the bypass
    `ACP_ASSERT(a_push_bypass, (stk_we && !i_in.is_last) |=> (w_rd == $past(r_top)),
        "stack bypass returned stale entry")
    // The nesting level stays within the stack
    `ACP_ASSERT(a_level_bound, in_acc |=> (r_level <= LW'(NEST_DEPTH)),
        "nesting level beyond stack depth")
    // A recorded error survives until its expression ends
    `ACP_ASSERT(a_err_sticky,
        ((r_err != ERR_NONE) && !(in_acc && i_in.is_last)) |=> (r_err == $past(r_err)),
        "sticky error lost")

endmodule
